// File: sv/ogpm_pkg.sv
// shared types and constants for the occupancy grid pose merge block
// no dependencies; used by ogpm_ctrl, ogpm_datapath and the top level
package ogpm_pkg;

    localparam int COORD_W = 8;
    localparam int COST_W  = 8;
    localparam int POSE_W  = 17;
    localparam int TRIG_W  = 16;
    localparam int CFG_W   = 17;
    localparam int CFG_IDX_W = 2;
    localparam int Q_FRAC  = 14;
    localparam int POSE_SHIFT = 6;

    typedef enum logic [1:0] {
        OP_MERGE = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_SPARE = 2'd3
    } ogpm_op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_POSE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POSE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN    = 2'd3;

    localparam logic signed [POSE_W-1:0] POSE_RESET = 17'sd0;
    localparam logic signed [TRIG_W-1:0] COS_RESET  = 16'sd16384;
    localparam logic signed [TRIG_W-1:0] SIN_RESET  = 16'sd0;

    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic addr;
        logic read;
        logic upd;
    } ogpm_cmd_t;

    typedef struct packed {
        logic is_merge;
    } ogpm_stat_t;

endpackage

// File: sv/ogpm_ctrl.sv
// sequencing state machine of the pose merge block
// uses ogpm_pkg; drives ogpm_datapath through command and status structs
module ogpm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  ogpm_pkg::ogpm_stat_t  stat,
    output ogpm_pkg::ogpm_cmd_t   cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_SUM  = 6'b000100,
        ST_ADDR = 6'b001000,
        ST_READ = 6'b010000,
        ST_UPD  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = stat.is_merge ? ST_SUM : ST_ADDR;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                cmd.addr   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (out_free)
                begin
                    cmd.upd    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.upd)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // a result is never loaded over one that is still waiting
    a_upd_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd |-> (!out_valid_reg || out_ready))
        else $error("result loaded while output register busy");

    // an accepted item always starts at the multiply step
    a_accept_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_MUL))
        else $error("accepted item did not enter multiply step");

    // a new result appears only after an update step
    a_rose_upd: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.upd))
        else $error("output valid without update");

    // no new item while the current one is still at work
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !(cmd.mul || cmd.sum || cmd.addr || cmd.read || cmd.upd))
        else $error("input ready while item in flight");

endmodule

// File: sv/ogpm_datapath.sv
// transform, map memory and output register of the pose merge block
// uses ogpm_pkg; sequenced by ogpm_ctrl
module ogpm_datapath #(
    parameter int GRID_DIM = 256
) (
    input  logic                                   clk,
    input  ogpm_pkg::ogpm_cmd_t                    cmd,
    output ogpm_pkg::ogpm_stat_t                   stat,
    input  logic signed [ogpm_pkg::POSE_W-1:0]     pose_x,
    input  logic signed [ogpm_pkg::POSE_W-1:0]     pose_y,
    input  logic signed [ogpm_pkg::TRIG_W-1:0]     trig_cos,
    input  logic signed [ogpm_pkg::TRIG_W-1:0]     trig_sin,
    input  logic [1:0]                             opcode,
    input  logic [ogpm_pkg::COORD_W-1:0]           cell_col,
    input  logic [ogpm_pkg::COORD_W-1:0]           cell_row,
    input  logic signed [ogpm_pkg::COST_W-1:0]     cost,
    output logic [ogpm_pkg::COORD_W-1:0]           target_col,
    output logic [ogpm_pkg::COORD_W-1:0]           target_row,
    output logic signed [ogpm_pkg::COST_W-1:0]     cell_value,
    output logic                                   in_range,
    output logic                                   written
);

    localparam int HALF   = GRID_DIM / 2;
    localparam int CLOG   = $clog2(GRID_DIM);
    localparam int LOC_W  = ((CLOG > ogpm_pkg::COORD_W) ? CLOG : ogpm_pkg::COORD_W) + 1;
    localparam int PROD_W = LOC_W + ogpm_pkg::TRIG_W;
    localparam int SUM_W  = ((PROD_W > 24) ? PROD_W : 24) + 3;
    localparam int T_W    = SUM_W - ogpm_pkg::Q_FRAC;
    localparam int DEPTH  = GRID_DIM * GRID_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam longint CENTER_Q = longint'(HALF) * (longint'(1) << ogpm_pkg::Q_FRAC);
    localparam logic signed [SUM_W-1:0] CENTER = SUM_W'(CENTER_Q);

    logic signed [ogpm_pkg::COST_W-1:0] map_mem [DEPTH];

    ogpm_pkg::ogpm_op_t                 op_reg;
    logic [ogpm_pkg::COORD_W-1:0]       col_reg;
    logic [ogpm_pkg::COORD_W-1:0]       row_reg;
    logic signed [ogpm_pkg::COST_W-1:0] cost_reg;

    logic signed [LOC_W-1:0]  lx;
    logic signed [LOC_W-1:0]  ly;
    logic signed [PROD_W-1:0] xc_reg;
    logic signed [PROD_W-1:0] ys_reg;
    logic signed [PROD_W-1:0] xs_reg;
    logic signed [PROD_W-1:0] yc_reg;

    logic signed [SUM_W-1:0] px_ext;
    logic signed [SUM_W-1:0] py_ext;
    logic signed [SUM_W-1:0] gx_next;
    logic signed [SUM_W-1:0] gy_next;
    logic signed [SUM_W-1:0] gx_reg;
    logic signed [SUM_W-1:0] gy_reg;

    logic [T_W-1:0]    tx_next;
    logic [T_W-1:0]    ty_next;
    logic              inr_next;
    logic [T_W-1:0]    tx_reg;
    logic [T_W-1:0]    ty_reg;
    logic              inr_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;

    logic signed [ogpm_pkg::COST_W-1:0] rd_reg;
    logic signed [ogpm_pkg::COST_W-1:0] new_val;
    logic                               wr_flag;

    logic [ogpm_pkg::COORD_W-1:0]       tcol_reg;
    logic [ogpm_pkg::COORD_W-1:0]       trow_reg;
    logic signed [ogpm_pkg::COST_W-1:0] val_reg;
    logic                               inr_out_reg;
    logic                               wr_out_reg;

    assign stat.is_merge = (op_reg == ogpm_pkg::OP_MERGE);

    // offsets from the local centre, whole cells
    assign lx = $signed(LOC_W'(col_reg)) - $signed(LOC_W'(HALF));
    assign ly = $signed(LOC_W'(row_reg)) - $signed(LOC_W'(HALF));

    assign px_ext = {{(SUM_W-ogpm_pkg::POSE_W){pose_x[ogpm_pkg::POSE_W-1]}}, pose_x};
    assign py_ext = {{(SUM_W-ogpm_pkg::POSE_W){pose_y[ogpm_pkg::POSE_W-1]}}, pose_y};

    always_comb
    begin
        gx_next = CENTER + (px_ext <<< ogpm_pkg::POSE_SHIFT)
                + {{(SUM_W-PROD_W){xc_reg[PROD_W-1]}}, xc_reg}
                - {{(SUM_W-PROD_W){ys_reg[PROD_W-1]}}, ys_reg};
        gy_next = CENTER + (py_ext <<< ogpm_pkg::POSE_SHIFT)
                + {{(SUM_W-PROD_W){xs_reg[PROD_W-1]}}, xs_reg}
                + {{(SUM_W-PROD_W){yc_reg[PROD_W-1]}}, yc_reg};
    end

    // floor to cells is the arithmetic shift; plain access uses the coordinates as given
    always_comb
    begin
        if (op_reg == ogpm_pkg::OP_MERGE)
        begin
            tx_next = gx_reg[SUM_W-1:ogpm_pkg::Q_FRAC];
            ty_next = gy_reg[SUM_W-1:ogpm_pkg::Q_FRAC];
        end
        else
        begin
            tx_next = T_W'(col_reg);
            ty_next = T_W'(row_reg);
        end
        inr_next = !tx_next[T_W-1] && (tx_next < T_W'(GRID_DIM))
                && !ty_next[T_W-1] && (ty_next < T_W'(GRID_DIM));
        addr_next = ADDR_W'(ty_next[CLOG-1:0]) * ADDR_W'(GRID_DIM)
                  + ADDR_W'(tx_next[CLOG-1:0]);
    end

    // merge keeps the signed maximum; a zero cost leaves the cell alone
    always_comb
    begin
        new_val = rd_reg;
        wr_flag = 1'b0;
        case (op_reg)
            ogpm_pkg::OP_MERGE:
            begin
                if (cost_reg != '0)
                begin
                    wr_flag = 1'b1;
                    if (cost_reg > rd_reg)
                        new_val = cost_reg;
                end
            end
            ogpm_pkg::OP_WRITE:
            begin
                wr_flag = 1'b1;
                new_val = cost_reg;
            end
            default:
            begin
                new_val = rd_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= ogpm_pkg::ogpm_op_t'(opcode);
            col_reg  <= cell_col;
            row_reg  <= cell_row;
            cost_reg <= cost;
        end
        if (cmd.mul)
        begin
            xc_reg <= PROD_W'(lx) * PROD_W'(trig_cos);
            ys_reg <= PROD_W'(ly) * PROD_W'(trig_sin);
            xs_reg <= PROD_W'(lx) * PROD_W'(trig_sin);
            yc_reg <= PROD_W'(ly) * PROD_W'(trig_cos);
        end
        if (cmd.sum)
        begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
        end
        if (cmd.addr)
        begin
            tx_reg   <= tx_next;
            ty_reg   <= ty_next;
            inr_reg  <= inr_next;
            addr_reg <= addr_next;
        end
        if (cmd.upd)
        begin
            tcol_reg    <= tx_reg[ogpm_pkg::COORD_W-1:0];
            trow_reg    <= ty_reg[ogpm_pkg::COORD_W-1:0];
            inr_out_reg <= inr_reg;
            wr_out_reg  <= inr_reg && wr_flag;
            val_reg     <= inr_reg ? new_val : '0;
        end
    end

    // map memory: one registered read, at most one write per item
    always_ff @(posedge clk)
    begin
        if (cmd.read)
            rd_reg <= map_mem[addr_reg];
        if (cmd.upd && inr_reg && wr_flag)
            map_mem[addr_reg] <= new_val;
    end

    assign target_col = tcol_reg;
    assign target_row = trow_reg;
    assign cell_value = val_reg;
    assign in_range   = inr_out_reg;
    assign written    = wr_out_reg;

endmodule

// File: sv/occupancy_grid_pose_merge.sv
// items are taken one at a time: a new item is accepted only after the last one's update step;
//   the steps run one after another: load, multiply, sum (merges only), address, memory
//   read and update, and the update step waits while the output register holds a result
// reset: pose registers to zero, heading to cos 1.0 and sin 0, no item in flight;
//   the map itself is not cleared and holds no defined value until written
// top level: configuration registers, controller and datapath; uses ogpm_pkg
module occupancy_grid_pose_merge #(
    parameter int GRID_DIM = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [ogpm_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [ogpm_pkg::CFG_W-1:0]          cfg_data,
    // input item channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          opcode,
    input  logic [ogpm_pkg::COORD_W-1:0]        cell_col,
    input  logic [ogpm_pkg::COORD_W-1:0]        cell_row,
    input  logic signed [ogpm_pkg::COST_W-1:0]  cost,
    // result item channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ogpm_pkg::COORD_W-1:0]        target_col,
    output logic [ogpm_pkg::COORD_W-1:0]        target_row,
    output logic signed [ogpm_pkg::COST_W-1:0]  cell_value,
    output logic                                in_range,
    output logic                                written
);

    // robot pose in cell units (8 fractional bits) and heading (14 fractional bits)
    logic signed [ogpm_pkg::POSE_W-1:0] pose_x_reg;
    logic signed [ogpm_pkg::POSE_W-1:0] pose_y_reg;
    logic signed [ogpm_pkg::TRIG_W-1:0] cos_reg;
    logic signed [ogpm_pkg::TRIG_W-1:0] sin_reg;

    ogpm_pkg::ogpm_cmd_t  cmd;
    ogpm_pkg::ogpm_stat_t stat;

    // writes take effect at once; user issues them only with no item in flight; not enforced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_x_reg <= ogpm_pkg::POSE_RESET;
            pose_y_reg <= ogpm_pkg::POSE_RESET;
            cos_reg    <= ogpm_pkg::COS_RESET;
            sin_reg    <= ogpm_pkg::SIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                ogpm_pkg::CFG_POSE_X: pose_x_reg <= cfg_data;
                ogpm_pkg::CFG_POSE_Y: pose_y_reg <= cfg_data;
                ogpm_pkg::CFG_COS:    cos_reg    <= cfg_data[ogpm_pkg::TRIG_W-1:0];
                ogpm_pkg::CFG_SIN:    sin_reg    <= cfg_data[ogpm_pkg::TRIG_W-1:0];
                default:              pose_x_reg <= pose_x_reg;
            endcase
        end
    end

    // controller: one item at a time, result held in the output register
    ogpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: rotate, translate, floor, range check, map read-modify-write
    ogpm_datapath #(
        .GRID_DIM (GRID_DIM)
    ) u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .stat       (stat),
        .pose_x     (pose_x_reg),
        .pose_y     (pose_y_reg),
        .trig_cos   (cos_reg),
        .trig_sin   (sin_reg),
        .opcode     (opcode),
        .cell_col   (cell_col),
        .cell_row   (cell_row),
        .cost       (cost),
        .target_col (target_col),
        .target_row (target_row),
        .cell_value (cell_value),
        .in_range   (in_range),
        .written    (written)
    );

endmodule

// File: sim/tb_occupancy_grid_pose_merge.sv
// testbench for occupancy_grid_pose_merge: global cost map with pose-rotated max merge
// predicts every result with its own copy of the map and pose registers; uses ogpm_pkg
// directed corner and special cases first, then random phases over many pose settings
module tb_occupancy_grid_pose_merge;

    localparam int COORD_W    = ogpm_pkg::COORD_W;
    localparam int COST_W     = ogpm_pkg::COST_W;
    localparam int POSE_W     = ogpm_pkg::POSE_W;
    localparam int TRIG_W     = ogpm_pkg::TRIG_W;
    localparam int CFG_W      = ogpm_pkg::CFG_W;
    localparam int CFG_IDX_W  = ogpm_pkg::CFG_IDX_W;
    localparam int Q_FRAC     = ogpm_pkg::Q_FRAC;
    localparam int POSE_SHIFT = ogpm_pkg::POSE_SHIFT;

    localparam int GRID_DIM    = 256;
    localparam int HALF        = GRID_DIM / 2;
    localparam int DRAIN_WAIT  = 8;        // extra wait after the last predicted result has come back
    localparam int CYCLE_LIMIT = 300_000;  // far beyond the slowest correct run
    localparam int PHASE_ITEMS = 56;       // 3 idle modes x 4 phases x 56 plus seeding writes

    // one result item as the block should report it
    typedef struct {
        logic [COORD_W-1:0]        col;
        logic [COORD_W-1:0]        row;
        logic signed [COST_W-1:0]  value;
        logic                      inr;
        logic                      wr;
    } grid_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_we;
    logic [CFG_IDX_W-1:0]        cfg_addr;
    logic [CFG_W-1:0]            cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic [1:0]                  opcode;
    logic [COORD_W-1:0]          cell_col;
    logic [COORD_W-1:0]          cell_row;
    logic signed [COST_W-1:0]    cost;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [COORD_W-1:0]          target_col;
    logic [COORD_W-1:0]          target_row;
    logic signed [COST_W-1:0]    cell_value;
    logic                        in_range;
    logic                        written;

    // predictor state: pose registers and the global map as the block should hold them
    logic signed [POSE_W-1:0]    pose_x;
    logic signed [POSE_W-1:0]    pose_y;
    logic signed [TRIG_W-1:0]    heading_cos;
    logic signed [TRIG_W-1:0]    heading_sin;
    logic signed [COST_W-1:0]    grid_cost [GRID_DIM*GRID_DIM];
    bit                          cell_known [GRID_DIM*GRID_DIM];
    int                          known_cells [$];   // addresses written at least once

    grid_result_t                grid_results_due [$];
    grid_result_t                oldest_due;

    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count;
    int fail_count;
    int n_items, n_merge, n_offmap, n_zero_merge, n_write, n_read, n_checked, n_phases;

    occupancy_grid_pose_merge #(
        .GRID_DIM(GRID_DIM)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .cell_col  (cell_col),
        .cell_row  (cell_row),
        .cost      (cost),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .target_col(target_col),
        .target_row(target_row),
        .cell_value(cell_value),
        .in_range  (in_range),
        .written   (written)
    );

    always #6 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles with %0d results outstanding",
                     cycle_count, grid_results_due.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stalls at random, driven away from the sampling edge
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (grid_results_due.size() == 0)
            begin
                $error("result item with nothing predicted (col %0d row %0d)",
                       target_col, target_row);
                fail_count++;
            end
            else
            begin
                oldest_due = grid_results_due.pop_front();
                check_field("target_col", oldest_due.col, target_col);
                check_field("target_row", oldest_due.row, target_row);
                check_field("cell_value", oldest_due.value, cell_value);
                check_field("in_range", oldest_due.inr, in_range);
                check_field("written", oldest_due.wr, written);
                n_checked++;
            end
        end
    end

    // global cell addressed by an item; merges go through rotation, offset and floor
    function automatic void locate_target(input ogpm_pkg::ogpm_op_t op,
                                          input logic [COORD_W-1:0] col,
                                          input logic [COORD_W-1:0] row,
                                          output int tx, output int ty);
        longint lx, ly, gx, gy;
        if (op == ogpm_pkg::OP_MERGE)
        begin
            lx = longint'(col) - HALF;
            ly = longint'(row) - HALF;
            gx = longint'(HALF) * (2 ** Q_FRAC) + longint'(pose_x) * (2 ** POSE_SHIFT)
                 + lx * longint'(heading_cos) - ly * longint'(heading_sin);
            gy = longint'(HALF) * (2 ** Q_FRAC) + longint'(pose_y) * (2 ** POSE_SHIFT)
                 + lx * longint'(heading_sin) + ly * longint'(heading_cos);
            // arithmetic shift floors toward minus infinity
            tx = int'(gx >>> Q_FRAC);
            ty = int'(gy >>> Q_FRAC);
        end
        else
        begin
            tx = col;
            ty = row;
        end
    endfunction

    function automatic bit on_map(int tx, int ty);
        return tx >= 0 && tx < GRID_DIM && ty >= 0 && ty < GRID_DIM;
    endfunction

    // update the map copy for one accepted item and queue the result it should give
    function automatic void predict_grid_access(ogpm_pkg::ogpm_op_t op,
                                                logic [COORD_W-1:0] col,
                                                logic [COORD_W-1:0] row,
                                                logic signed [COST_W-1:0] new_cost);
        int tx, ty, addr;
        grid_result_t res;
        locate_target(op, col, row, tx, ty);
        res.col   = tx[COORD_W-1:0];
        res.row   = ty[COORD_W-1:0];
        res.inr   = on_map(tx, ty);
        res.wr    = 1'b0;
        res.value = '0;
        n_items++;
        if (op == ogpm_pkg::OP_MERGE)
            n_merge++;
        else if (op == ogpm_pkg::OP_WRITE)
            n_write++;
        else
            n_read++;
        if (op == ogpm_pkg::OP_MERGE && !res.inr)
            n_offmap++;
        if (op == ogpm_pkg::OP_MERGE && new_cost == 0)
            n_zero_merge++;
        if (res.inr)
        begin
            addr = ty * GRID_DIM + tx;
            if (op == ogpm_pkg::OP_MERGE && new_cost != 0)
            begin
                // max fusion, -1 unknown loses to anything known
                if (new_cost > grid_cost[addr])
                    grid_cost[addr] = new_cost;
                res.wr = 1'b1;
            end
            else if (op == ogpm_pkg::OP_WRITE)
            begin
                grid_cost[addr] = new_cost;
                res.wr = 1'b1;
                if (!cell_known[addr])
                begin
                    cell_known[addr] = 1'b1;
                    known_cells.push_back(addr);
                end
            end
            res.value = grid_cost[addr];
        end
        grid_results_due.push_back(res);
    endfunction

    // one item: optional sender gap, then hold valid until the handshake
    task automatic send_item(ogpm_pkg::ogpm_op_t op, logic [COORD_W-1:0] col,
                             logic [COORD_W-1:0] row, logic signed [COST_W-1:0] new_cost);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        cell_col <= col;
        cell_row <= row;
        cost     <= new_cost;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_grid_access(op, col, row, new_cost);
    endtask

    // costs weighted toward the interesting values: free, unknown, fully occupied
    function automatic logic signed [COST_W-1:0] rand_cost();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 8'sd0;
            1:       return -8'sd1;
            2:       return 8'sd100;
            default: return COST_W'($urandom_range(1, 99));
        endcase
    endfunction

    task automatic send_merge_raw(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                                  logic signed [COST_W-1:0] new_cost);
        send_item(ogpm_pkg::OP_MERGE, col, row, new_cost);
    endtask

    // a merge onto a cell never written would read undefined memory, so seed it first
    task automatic send_merge(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                              logic signed [COST_W-1:0] new_cost);
        int tx, ty;
        locate_target(ogpm_pkg::OP_MERGE, col, row, tx, ty);
        if (on_map(tx, ty) && !cell_known[ty * GRID_DIM + tx])
            send_item(ogpm_pkg::OP_WRITE, tx[COORD_W-1:0], ty[COORD_W-1:0], rand_cost());
        send_merge_raw(col, row, new_cost);
    endtask

    // lower valid and let every predicted result come back before touching registers
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (grid_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        logic [31:0] bits;
        bits = value;
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= bits[CFG_W-1:0];
        case (idx)
            ogpm_pkg::CFG_POSE_X: pose_x      = bits[POSE_W-1:0];
            ogpm_pkg::CFG_POSE_Y: pose_y      = bits[POSE_W-1:0];
            ogpm_pkg::CFG_COS:    heading_cos = bits[TRIG_W-1:0];
            ogpm_pkg::CFG_SIN:    heading_sin = bits[TRIG_W-1:0];
            default:              ;
        endcase
    endtask

    // all four registers, only while the block is idle
    task automatic load_pose_heading(int px, int py, int c, int s);
        drain_results();
        write_reg(ogpm_pkg::CFG_POSE_X, px);
        write_reg(ogpm_pkg::CFG_POSE_Y, py);
        write_reg(ogpm_pkg::CFG_COS, c);
        write_reg(ogpm_pkg::CFG_SIN, s);
        @(negedge clk);
        cfg_we <= 1'b0;
        n_phases++;
    endtask

    function automatic int rand_trig();
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    function automatic int rand_pose(bit wide);
        if (wide)
            return int'($urandom_range(0, 131071)) - 65536;
        return int'($urandom_range(0, 8192)) - 4096;   // within 16 cells of the center
    endfunction

    task automatic send_random_item();
        int pick, addr;
        logic [COORD_W-1:0] col, row;
        ogpm_pkg::ogpm_op_t rd_op;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            // half the merges near the local center so fused cells get hit repeatedly
            if ($urandom_range(0, 1))
            begin
                col = COORD_W'(HALF - 5 + $urandom_range(0, 10));
                row = COORD_W'(HALF - 5 + $urandom_range(0, 10));
            end
            else
            begin
                col = COORD_W'($urandom_range(0, 255));
                row = COORD_W'($urandom_range(0, 255));
            end
            send_merge(col, row, rand_cost());
        end
        else if (pick < 75 || known_cells.size() == 0)
        begin
            if (known_cells.size() != 0 && $urandom_range(0, 1))
            begin
                addr = known_cells[$urandom_range(0, known_cells.size() - 1)];
                col  = COORD_W'(addr % GRID_DIM);
                row  = COORD_W'(addr / GRID_DIM);
            end
            else
            begin
                col = COORD_W'($urandom_range(0, 255));
                row = COORD_W'($urandom_range(0, 255));
            end
            send_item(ogpm_pkg::OP_WRITE, col, row, rand_cost());
        end
        else
        begin
            // reads only of cells already written; the spare opcode now and then
            addr = known_cells[$urandom_range(0, known_cells.size() - 1)];
            if ($urandom_range(0, 9) == 0)
                rd_op = ogpm_pkg::OP_SPARE;
            else
                rd_op = ogpm_pkg::OP_READ;
            send_item(rd_op, COORD_W'(addr % GRID_DIM), COORD_W'(addr / GRID_DIM),
                      rand_cost());
        end
    endtask

    // pose and heading of one random phase, extremes included
    task automatic configure_phase(int sel);
        case (sel % 6)
            0: load_pose_heading(rand_pose(0), rand_pose(0), 16384, 0);
            1: load_pose_heading(65535, -65536, rand_trig(), rand_trig());
            2: load_pose_heading(rand_pose(0), rand_pose(0), -16384, 16384);
            3: load_pose_heading(rand_pose(0), rand_pose(0), 0, -16384);
            4: load_pose_heading(rand_pose(1), rand_pose(1), rand_trig(), rand_trig());
            default: load_pose_heading(-65536, 65535, 16384, 16384);
        endcase
    endtask

    // directed: map corners, every opcode, max fusion rules, zero cost, off-map targets
    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_pose_heading(0, 0, 16384, 0);
        send_item(ogpm_pkg::OP_WRITE, 8'd0, 8'd0, 8'sd100);
        send_item(ogpm_pkg::OP_WRITE, 8'd255, 8'd255, -8'sd1);
        send_item(ogpm_pkg::OP_WRITE, 8'd255, 8'd0, 8'sd0);
        send_item(ogpm_pkg::OP_WRITE, 8'd0, 8'd255, 8'sd63);
        send_item(ogpm_pkg::OP_READ, 8'd0, 8'd0, 8'sd0);
        send_item(ogpm_pkg::OP_SPARE, 8'd255, 8'd255, -8'sd1);
        // identity pose: local cell maps onto the same global cell
        send_merge(8'd0, 8'd0, 8'sd50);        // lower cost leaves 100
        send_merge(8'd255, 8'd255, 8'sd100);   // unknown replaced
        send_merge(8'd255, 8'd0, -8'sd1);      // unknown never beats free
        send_merge(8'd0, 8'd255, 8'sd0);       // zero cost reports without writing
        send_item(ogpm_pkg::OP_WRITE, 8'd128, 8'd128, 8'sd1);
        send_merge(8'd128, 8'd128, 8'sd64);
        send_merge(8'd128, 8'd128, 8'sd64);    // same cell again right behind
        send_item(ogpm_pkg::OP_READ, 8'd128, 8'd128, 8'sd0);
        send_item(ogpm_pkg::OP_WRITE, 8'd128, 8'd128, 8'sd0);   // write stores zero as given
        // largest positive x pose: edge column, then one past it
        load_pose_heading(65535, 0, 16384, 0);
        send_merge(8'd0, 8'd0, 8'sd10);
        send_merge(8'd1, 8'd0, 8'sd10);
        // most negative pose, heading reversed
        load_pose_heading(-65536, -65536, -16384, 0);
        send_merge(8'd0, 8'd0, 8'sd20);
        send_merge(8'd255, 8'd255, 8'sd20);
        // quarter turn with the extreme sine
        load_pose_heading(0, 0, 0, 16384);
        send_merge(8'd200, 8'd40, 8'sd30);
        send_merge(8'd0, 8'd128, -8'sd1);
    endtask

    task automatic test_random(int send_pct, int recv_pct, int first_sel);
        for (int p = 0; p < 4; p++)
        begin
            configure_phase(first_sel + p);
            send_idle_pct = send_pct;
            recv_idle_pct = recv_pct;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_random_item();
        end
    endtask

    initial
    begin
        // every input known from time zero
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = ogpm_pkg::CFG_POSE_X;
        cfg_data  = '0;
        in_valid  = 1'b0;
        opcode    = ogpm_pkg::OP_READ;
        cell_col  = '0;
        cell_row  = '0;
        cost      = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        pose_x      = ogpm_pkg::POSE_RESET;
        pose_y      = ogpm_pkg::POSE_RESET;
        heading_cos = ogpm_pkg::COS_RESET;
        heading_sin = ogpm_pkg::SIN_RESET;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random(18, 57, 0);   // receiver mostly stalled
        test_random(57, 18, 4);   // sender mostly idle
        test_random(0, 0, 2);     // back to back
        drain_results();

        $display("items %0d: %0d merges (%0d off the map, %0d zero cost), %0d writes, %0d reads",
                 n_items, n_merge, n_offmap, n_zero_merge, n_write, n_read);
        $display("results checked %0d over %0d pose settings, %0d map cells touched",
                 n_checked, n_phases, known_cells.size());
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
